// ===== hw/rtl/md5_pkg.sv =====
// MD5 engine package: sequencer states, buffer write request, round tables.
// No dependencies; used by md5_msg_buf, md5_round and md5_hash_engine_core.
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd55;
    localparam logic [5:0]  LAST_POS = 6'd63;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD,
        RET_OUT
    } ret_t;

    typedef enum logic [1:0] {
        PH_F,
        PH_G,
        PH_H,
        PH_I
    } phase_t;

    typedef struct packed {
        logic        byte_en;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic        len_en;
        logic [63:0] bit_len;
    } buf_wr_t;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_shift(input logic [1:0] ph, input logic [1:0] q);
        logic [4:0] s;
        case ({ph, q})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/md5_msg_buf.sv =====
// MD5 message block buffer: sixteen 32-bit words, byte and length writes.
// Depends on md5_pkg for the write request type.
module md5_msg_buf
(
    input  logic             clk,
    input  md5_pkg::buf_wr_t wr,
    input  logic [3:0]       rd_idx,
    output logic [31:0]      rd_data
);

    logic [31:0] word_reg [16];

    always_ff @(posedge clk)
    begin
        if (wr.byte_en)
        begin
            word_reg[wr.pos[5:2]][{wr.pos[1:0], 3'b000} +: 8] <= wr.data;
        end
        if (wr.len_en)
        begin
            word_reg[md5_pkg::LEN_LO_WORD] <= wr.bit_len[31:0];
            word_reg[md5_pkg::LEN_HI_WORD] <= wr.bit_len[63:32];
        end
    end

    assign rd_data = word_reg[rd_idx];

endmodule

// ===== hw/rtl/md5_round.sv =====
// MD5 round unit: message word selection, round function, rotate and add.
// Depends on md5_pkg for the round constant and shift tables.
module md5_round
(
    input  logic [5:0]  rnd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] m,
    output logic [3:0]  g,
    output logic [31:0] new_b
);

    md5_pkg::phase_t ph;
    logic [3:0]  q;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot;
    logic [4:0]  sh;

    always_comb
    begin
        ph = md5_pkg::phase_t'(rnd[5:4]);
        q  = rnd[3:0];
        case (ph)
            md5_pkg::PH_F:
            begin
                f = (b & c) | (~b & d);
                g = q;
            end
            md5_pkg::PH_G:
            begin
                f = (d & b) | (~d & c);
                g = 4'((q << 2) + q + 4'd1);
            end
            md5_pkg::PH_H:
            begin
                f = b ^ c ^ d;
                g = 4'((q << 1) + q + 4'd5);
            end
            md5_pkg::PH_I:
            begin
                f = c ^ (b | ~d);
                g = 4'((q << 3) - q);
            end
            default:
            begin
                f = 32'h0;
                g = 4'd0;
            end
        endcase
        sh    = md5_pkg::round_shift(rnd[5:4], q[1:0]);
        sum   = a + f + md5_pkg::round_const(rnd) + m;
        rot   = {sum, sum} << sh;
        new_b = b + rot[63:32];
    end

endmodule

// ===== hw/rtl/md5_hash_engine_core.sv =====
// MD5 engine top level: stream ports, sequencer, counters and chaining value.
// Depends on md5_pkg, md5_round and md5_msg_buf.
//
// Message bytes are taken one per cycle while the block is ready. The 64th
// byte of a block starts a compression (64 rounds through the single round
// unit, then the chaining add) during which no byte is taken. An item with
// tlast pads one byte position per cycle up to position 55 (through 63 and
// again from 0 when fewer than 9 positions remain, with one more
// compression), writes the length, compresses, and then offers the
// digest as four words A..D; the next message starts after the fourth
// word is taken.
module md5_hash_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);

    md5_pkg::state_t state_reg, state_next;
    md5_pkg::ret_t   ret_reg, ret_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [5:0]  pad_pos_reg, pad_pos_next;
    logic        mark_done_reg, mark_done_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] rw_reg [4];
    logic [31:0] rw_next [4];

    md5_pkg::buf_wr_t wr;
    logic [3:0]  g;
    logic [31:0] m_word;
    logic [31:0] new_b;
    logic [5:0]  pos;
    logic        start_cmp;

    md5_round u_round
    (
        .rnd   (rnd_reg),
        .a     (rw_reg[0]),
        .b     (rw_reg[1]),
        .c     (rw_reg[2]),
        .d     (rw_reg[3]),
        .m     (m_word),
        .g     (g),
        .new_b (new_b)
    );

    md5_msg_buf u_buf
    (
        .clk     (clk),
        .wr      (wr),
        .rd_idx  (g),
        .rd_data (m_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            ret_reg       <= md5_pkg::RET_IDLE;
            cnt_reg       <= 64'd0;
            rnd_reg       <= 6'd0;
            pad_pos_reg   <= 6'd0;
            mark_done_reg <= 1'b0;
            out_idx_reg   <= 2'd0;
            chain_reg[0]  <= md5_pkg::IV_A;
            chain_reg[1]  <= md5_pkg::IV_B;
            chain_reg[2]  <= md5_pkg::IV_C;
            chain_reg[3]  <= md5_pkg::IV_D;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            rnd_reg       <= rnd_next;
            pad_pos_reg   <= pad_pos_next;
            mark_done_reg <= mark_done_next;
            out_idx_reg   <= out_idx_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg <= rw_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        rnd_next       = rnd_reg;
        pad_pos_next   = pad_pos_reg;
        mark_done_next = mark_done_reg;
        out_idx_next   = out_idx_reg;
        chain_next     = chain_reg;
        rw_next        = rw_reg;
        start_cmp      = 1'b0;
        pos            = cnt_reg[5:0];
        wr.byte_en     = 1'b0;
        wr.pos         = pos;
        wr.data        = s_axis_tdata;
        wr.len_en      = 1'b0;
        wr.bit_len     = {cnt_reg[60:0], 3'b000};
        s_axis_tready  = 1'b0;
        m_axis_tvalid  = 1'b0;

        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    mark_done_next = 1'b0;
                    if (s_axis_tuser[0])
                    begin
                        wr.byte_en = 1'b1;
                        cnt_next   = cnt_reg + 64'd1;
                    end
                    if (s_axis_tuser[0] && pos == md5_pkg::LAST_POS)
                    begin
                        start_cmp = 1'b1;
                        ret_next  = s_axis_tlast ? md5_pkg::RET_PAD : md5_pkg::RET_IDLE;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next   = md5_pkg::ST_PAD;
                        pad_pos_next = cnt_next[5:0];
                    end
                end
            end
            md5_pkg::ST_ROUND:
            begin
                rw_next[0] = rw_reg[3];
                rw_next[1] = new_b;
                rw_next[2] = rw_reg[1];
                rw_next[3] = rw_reg[2];
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == md5_pkg::LAST_ROUND)
                begin
                    state_next = md5_pkg::ST_ADD;
                end
            end
            md5_pkg::ST_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    chain_next[i] = chain_reg[i] + rw_reg[i];
                end
                case (ret_reg)
                    md5_pkg::RET_PAD:
                    begin
                        state_next   = md5_pkg::ST_PAD;
                        pad_pos_next = 6'd0;
                    end
                    md5_pkg::RET_OUT:
                    begin
                        state_next   = md5_pkg::ST_OUT;
                        out_idx_next = 2'd0;
                    end
                    default:
                    begin
                        state_next = md5_pkg::ST_IDLE;
                    end
                endcase
            end
            md5_pkg::ST_PAD:
            begin
                wr.byte_en     = 1'b1;
                wr.pos         = pad_pos_reg;
                wr.data        = mark_done_reg ? 8'h00 : md5_pkg::PAD_MARK;
                mark_done_next = 1'b1;
                if (pad_pos_reg == md5_pkg::LEN_POS)
                begin
                    state_next = md5_pkg::ST_LEN;
                end
                else if (pad_pos_reg == md5_pkg::LAST_POS)
                begin
                    start_cmp = 1'b1;
                    ret_next  = md5_pkg::RET_PAD;
                end
                else
                begin
                    pad_pos_next = pad_pos_reg + 6'd1;
                end
            end
            md5_pkg::ST_LEN:
            begin
                wr.len_en = 1'b1;
                start_cmp = 1'b1;
                ret_next  = md5_pkg::RET_OUT;
            end
            md5_pkg::ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    if (out_idx_reg == 2'd3)
                    begin
                        state_next    = md5_pkg::ST_IDLE;
                        cnt_next      = 64'd0;
                        chain_next[0] = md5_pkg::IV_A;
                        chain_next[1] = md5_pkg::IV_B;
                        chain_next[2] = md5_pkg::IV_C;
                        chain_next[3] = md5_pkg::IV_D;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase

        if (start_cmp)
        begin
            state_next = md5_pkg::ST_ROUND;
            rnd_next   = 6'd0;
            rw_next    = chain_reg;
        end
    end

    assign m_axis_tdata = chain_reg[out_idx_reg];
    assign m_axis_tuser = out_idx_reg;
    assign m_axis_tlast = (out_idx_reg == 2'd3);

endmodule

// ===== hw/rtl/md5_checker.sv =====
// Port checker for the MD5 engine top level, attached by bind.
// Depends only on the ports of md5_hash_engine_core.
module md5_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest offered");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("digest word index did not advance");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("last flag not on word D");

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after digest");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("ready right after message end");

endmodule

bind md5_hash_engine_core md5_checker u_md5_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/md5_digest_check_pkg.sv =====
`timescale 1ns / 100ps
// Digest scoreboard for the MD5 stream engine: a behavioral MD5 that turns accepted
// requests into expected digest words and checks the engine's words in order.
// Standalone package; used by tb_md5_hash_engine_core.
package md5_digest_check_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } digest_beat_t;

    class md5_digest_board;
        logic [31:0]  chain [4];
        logic [31:0]  blk [16];
        logic [63:0]  msg_bytes;
        digest_beat_t digest_due [$];
        int unsigned  mismatches;
        int unsigned  words_checked;

        function new();
            mismatches = 0;
            words_checked = 0;
            foreach (blk[i])
                blk[i] = '0;
            rearm();
        endfunction

        function void rearm();
            chain[0] = INIT_A;
            chain[1] = INIT_B;
            chain[2] = INIT_C;
            chain[3] = INIT_D;
            msg_bytes = '0;
        endfunction

        function void put_byte(int unsigned pos, logic [7:0] v);
            int unsigned w;
            int unsigned sh;
            w = (pos >> 2) & 15;
            sh = (pos & 3) * 8;
            if ((pos & 3) == 0)
                blk[w] = {24'h0, v};
            else
                blk[w][sh +: 8] = v;
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, t;
            int unsigned g, s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++)
            begin
                case (r / 16)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = r % 16;
                    end
                    1:
                    begin
                        f = (d & b) | (~d & c);
                        g = (5 * (r % 16) + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * (r % 16) + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * (r % 16)) % 16;
                    end
                endcase
                s = ROT_AMT[(r / 16) * 4 + (r % 4)];
                t = a + f + SINE_K[r] + blk[g];
                t = (t << s) | (t >> (32 - s));
                a = d;
                d = c;
                c = b;
                b = b + t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_request(logic [7:0] data, logic present, logic eom);
            int unsigned pos;
            logic [63:0] bit_len;
            digest_beat_t beat;
            if (present)
            begin
                pos = 32'(msg_bytes[5:0]);
                put_byte(pos, data);
                msg_bytes++;
                if (pos == 63)
                    compress();
            end
            if (!eom)
                return;
            pos = 32'(msg_bytes[5:0]);
            put_byte(pos, PAD_BYTE);
            for (int unsigned i = pos + 1; i < 64; i++)
                put_byte(i, 8'h00);
            if (pos >= 56)
            begin
                compress();
                foreach (blk[i])
                    blk[i] = '0;
            end
            bit_len = msg_bytes << 3;
            blk[14] = bit_len[31:0];
            blk[15] = bit_len[63:32];
            compress();
            for (int i = 0; i < 4; i++)
            begin
                beat.word = chain[i];
                beat.index = i[1:0];
                beat.last = (i == 3);
                digest_due.push_back(beat);
            end
            rearm();
        endfunction

        function void check_result(logic [31:0] word, logic [1:0] index, logic last);
            digest_beat_t want;
            words_checked++;
            if (digest_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected digest word %h index %0d last %0b",
                             word, index, last);
                return;
            end
            want = digest_due.pop_front();
            if (want.word !== word || want.index !== index || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: digest word #%0d: expected %h/%0d/%0b, got %h/%0d/%0b",
                             words_checked, want.word, want.index, want.last,
                             word, index, last);
            end
        endfunction

        function int unsigned pending();
            return digest_due.size();
        endfunction

        function int unsigned failures();
            return mismatches + digest_due.size();
        endfunction
    endclass

endpackage

// ===== test/tb_md5_hash_engine_core.sv =====
`timescale 1ns / 100ps
// Top-level testbench for md5_hash_engine_core: drives byte requests in bursts,
// stalls the digest side, and checks every digest word against the scoreboard.
// Depends on md5_digest_check_pkg and the engine RTL.
module tb_md5_hash_engine_core;

    localparam int unsigned EDGE_LEN [12] = '{
        55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;      // [0] byte_present
    logic        s_axis_tlast = 1'b0;      // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // [31:0] digest_word
    logic [1:0]  m_axis_tuser;             // [1:0] word_index
    logic        m_axis_tlast;             // last_word

    md5_digest_check_pkg::md5_digest_board board;
    int unsigned     req_count = 0;
    int unsigned     msg_count = 0;
    int unsigned     words_seen = 0;
    int unsigned     burst_left = 0;

    md5_hash_engine_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("FAIL md5_hash_engine_core");
        $finish;
    end

    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= present;
        s_axis_tlast <= eom;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        board.note_request(data, present, eom);
        req_count++;
        if (eom)
            msg_count++;
    endtask

    task automatic send_message(input int unsigned len, input bit end_on_byte);
        for (int unsigned k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // digest side: check accepted words, then pick the next ready level
    initial
    begin : digest_sink
        int unsigned hold_left;
        int unsigned rx_cyc;
        bit          long_hold_done;
        hold_left = 0;
        rx_cyc = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                words_seen++;
            end
            rx_cyc++;
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!long_hold_done && words_seen >= 24 && m_axis_tvalid)
            begin
                // hold off long enough for the engine to back up into its input
                long_hold_done = 1'b1;
                hold_left = 600;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cyc / 97) % 4)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= (rx_cyc % 3) == 0;
                    2: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= (rx_cyc % 8) < 5;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int unsigned len;
        int unsigned sel;
        bit          end_on_byte;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);

        while (req_count < 470 || msg_count < 12)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                len = $urandom_range(0, 20);
            else if (sel < 8)
                len = EDGE_LEN[$urandom_range(0, 11)];
            else
                len = $urandom_range(0, 140);
            end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
            send_message(len, end_on_byte);
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.failures() == 0)
            $display("PASS md5_hash_engine_core");
        else
            $display("FAIL md5_hash_engine_core");
        $finish;
    end

endmodule
